[hw/rtl/dwc_pkg.sv]
// ----------------------------------------------------------------------------
// Depthwise convolution package
// Shared constants, register indexes and word types of the depthwise
// valid convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package dwc_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned MaxHeight   = 1024;
  localparam int unsigned MaxKernel   = 5;
  localparam int unsigned NumLines    = MaxKernel - 1;
  localparam int unsigned MaxChannels = 64;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned ProdBits    = 2 * SampleBits;
  localparam int unsigned RowSumBits  = ProdBits + 3;
  localparam int unsigned SumBits     = 40;
  localparam int unsigned LineAw      = $clog2(MaxWidth);
  localparam int unsigned ChanAw      = $clog2(MaxChannels);
  localparam int unsigned FifoDepth   = 8;
  localparam int unsigned FifoAw      = $clog2(FifoDepth);

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_KERNEL_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_KERNEL_HEIGHT = 2'd3;

  // Input word modes.
  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_PIXEL  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [5:0]         channel;
    logic [2:0]         kernel_row;
    logic [2:0]         kernel_col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] sum;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic [5:0]         out_channel;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/dwc_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, read-first, registered read data with read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module dwc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // A read at the written address returns the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/depthwise_valid_conv2d_top.sv]
// ----------------------------------------------------------------------------
// Depthwise valid 2-D convolution
// Streams pixel planes through line memories and a 5x5 window and gives one
// exact sum of products per complete kernel window.
// ----------------------------------------------------------------------------
// The block takes one word per clock, weight or pixel, and keeps that rate
// for as long as the result side takes its words. A pixel that completes a
// kernel window gives its sum after registered steps in order: the line
// and weight memory reads, the window shift, the 25 multipliers and the
// row sums of the adder tree, then its final add. Results collect
// in an eight-word output queue; the input stalls only when the words in
// flight and queued would fill that queue, so a stalled result side costs
// no input throughput until the queue is full. Weights live in 25 small
// memories (one per kernel position, addressed by channel) and the previous
// four image rows in four line memories addressed by column; each is read
// and written once in the cycle a word is accepted, so no forwarding is
// needed. Memories start undefined: windows that use weights never loaded
// give undefined sums. The configuration port is always ready; a write also
// restarts the plane position, and it must only happen while the block is
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module depthwise_valid_conv2d_top
  import dwc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  // Configuration registers.
  logic [10:0] img_w_q, img_h_q;
  logic [2:0]  ker_w_q, ker_h_q;
  logic [10:0] w_c, h_c;
  logic [2:0]  kw_c, kh_c;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 11'd1024;
      img_h_q <= 11'd1024;
      ker_w_q <= 3'd3;
      ker_h_q <= 3'd3;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:   img_w_q <= cfg_data_i;
        CFG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        CFG_KERNEL_WIDTH:  ker_w_q <= cfg_data_i[2:0];
        CFG_KERNEL_HEIGHT: ker_h_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping to the supported ranges.
  always_comb begin
    w_c  = (img_w_q == 11'd0) ? 11'd1 :
           (img_w_q > 11'(MaxWidth)) ? 11'(MaxWidth) : img_w_q;
    h_c  = (img_h_q == 11'd0) ? 11'd1 :
           (img_h_q > 11'(MaxHeight)) ? 11'(MaxHeight) : img_h_q;
    kw_c = (ker_w_q == 3'd0) ? 3'd1 :
           (ker_w_q > 3'(MaxKernel)) ? 3'(MaxKernel) : ker_w_q;
    kh_c = (ker_h_q == 3'd0) ? 3'd1 :
           (ker_h_q > 3'(MaxKernel)) ? 3'(MaxKernel) : ker_h_q;
  end

  // Input acceptance and plane position.
  logic       in_acc, pix_acc, wgt_acc, produce;
  logic [9:0] row_q, col_q;
  logic       row_end, col_end;
  logic [3:0] occ_q;

  assign in_stall_o = (occ_q == 4'(FifoDepth));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (in_data_i.mode == MODE_PIXEL);
  assign wgt_acc    = in_acc && (in_data_i.mode == MODE_WEIGHT);
  assign col_end    = ({1'b0, col_q} + 11'd1) == w_c;
  assign row_end    = ({1'b0, row_q} + 11'd1) == h_c;
  assign produce    = pix_acc && ({1'b0, row_q} + 11'd1 >= {8'd0, kh_c})
                              && ({1'b0, col_q} + 11'd1 >= {8'd0, kw_c});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (pix_acc) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? 10'd0 : row_q + 10'd1;
      end else begin
        col_q <= col_q + 10'd1;
      end
    end
  end

  // Line memories: slot i holds the rows whose number is i modulo four.
  logic signed [15:0] line_rd [NumLines];

  for (genvar i = 0; i < NumLines; i++) begin : g_line
    dwc_ram #(.Width(SampleBits), .Depth(MaxWidth)) u_line (
      .clk_i   (clk_i),
      .we_i    (pix_acc && (row_q[1:0] == 2'(i))),
      .re_i    (pix_acc),
      .addr_i  (col_q),
      .wdata_i (in_data_i.value),
      .rdata_o (line_rd[i])
    );
  end

  // Weight memories: one per kernel position, addressed by channel.
  logic signed [15:0] wgt_rd [MaxKernel][MaxKernel];

  for (genvar ky = 0; ky < MaxKernel; ky++) begin : g_wrow
    for (genvar kx = 0; kx < MaxKernel; kx++) begin : g_wcol
      dwc_ram #(.Width(SampleBits), .Depth(MaxChannels)) u_wgt (
        .clk_i   (clk_i),
        .we_i    (wgt_acc && (in_data_i.kernel_row == 3'(ky))
                          && (in_data_i.kernel_col == 3'(kx))),
        .re_i    (pix_acc),
        .addr_i  (in_data_i.channel),
        .wdata_i (in_data_i.value),
        .rdata_o (wgt_rd[ky][kx])
      );
    end
  end

  // Stage 1: memory data is out; the window column is formed.
  logic               s1_vld_q, s1_res_q, s1_last_q;
  logic signed [15:0] s1_val_q;
  logic [9:0]         s1_row_q, s1_col_q;
  logic [5:0]         s1_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_res_q <= 1'b0;
    end else begin
      s1_vld_q <= pix_acc;
      s1_res_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_val_q  <= in_data_i.value;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_ch_q   <= in_data_i.channel;
      s1_last_q <= row_end && col_end;
    end
  end

  logic signed [15:0] new_col [MaxKernel];

  always_comb begin
    logic [2:0] line_back;
    logic [1:0] slot;
    line_back = '0;
    slot      = '0;
    for (int ky = 0; ky < MaxKernel; ky++) begin
      if (3'(ky) + 3'd1 == kh_c) begin
        new_col[ky] = s1_val_q;
      end else begin
        line_back   = kh_c - 3'(ky) - 3'd1;
        slot        = s1_row_q[1:0] - line_back[1:0];
        new_col[ky] = line_rd[slot];
      end
    end
  end

  // Stage 2: window and weights held in registers.
  logic signed [15:0] win_q [MaxKernel][MaxKernel];
  logic signed [15:0] wgt_q [MaxKernel][MaxKernel];
  logic               s2_res_q, s2_last_q;
  logic [9:0]         s2_orow_q, s2_ocol_q;
  logic [5:0]         s2_ch_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      for (int ky = 0; ky < MaxKernel; ky++) begin
        for (int kx = 0; kx < MaxKernel - 1; kx++) begin
          win_q[ky][kx] <= win_q[ky][kx+1];
        end
        win_q[ky][MaxKernel-1] <= new_col[ky];
        for (int kx = 0; kx < MaxKernel; kx++) begin
          wgt_q[ky][kx] <= wgt_rd[ky][kx];
        end
      end
      s2_orow_q <= s1_row_q + 10'd1 - {7'd0, kh_c};
      s2_ocol_q <= s1_col_q + 10'd1 - {7'd0, kw_c};
      s2_ch_q   <= s1_ch_q;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: products; the weight at (ky, kx) meets window column
  // MaxKernel - kw + kx, so the window's used columns sit at the right.
  // The column test runs one bit wider so that kx + kw cannot wrap.
  logic signed [31:0] prod_q [MaxKernel][MaxKernel];
  logic               s3_res_q, s3_last_q;
  logic [9:0]         s3_orow_q, s3_ocol_q;
  logic [5:0]         s3_ch_q;

  always_ff @(posedge clk_i) begin
    for (int ky = 0; ky < MaxKernel; ky++) begin
      for (int kx = 0; kx < MaxKernel; kx++) begin
        if ((3'(ky) < kh_c) && (4'(kx) + {1'b0, kw_c} >= 4'(MaxKernel))) begin
          prod_q[ky][kx] <= win_q[ky][kx]
                          * wgt_q[ky][3'(4'(kx) + {1'b0, kw_c} - 4'(MaxKernel))];
        end else begin
          prod_q[ky][kx] <= '0;
        end
      end
    end
    s3_orow_q <= s2_orow_q;
    s3_ocol_q <= s2_ocol_q;
    s3_ch_q   <= s2_ch_q;
    s3_last_q <= s2_last_q;
  end

  // Stage 4: one sum per kernel row.
  logic signed [RowSumBits-1:0] rsum_q [MaxKernel];
  logic                         s4_res_q, s4_last_q;
  logic [9:0]                   s4_orow_q, s4_ocol_q;
  logic [5:0]                   s4_ch_q;

  always_ff @(posedge clk_i) begin
    for (int ky = 0; ky < MaxKernel; ky++) begin
      rsum_q[ky] <= RowSumBits'(prod_q[ky][0]) + RowSumBits'(prod_q[ky][1])
                  + RowSumBits'(prod_q[ky][2]) + RowSumBits'(prod_q[ky][3])
                  + RowSumBits'(prod_q[ky][4]);
    end
    s4_orow_q <= s3_orow_q;
    s4_ocol_q <= s3_ocol_q;
    s4_ch_q   <= s3_ch_q;
    s4_last_q <= s3_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_res_q <= 1'b0;
      s3_res_q <= 1'b0;
      s4_res_q <= 1'b0;
    end else begin
      s2_res_q <= s1_res_q;
      s3_res_q <= s2_res_q;
      s4_res_q <= s3_res_q;
    end
  end

  // Final add and output queue.
  out_item_t push_word;

  always_comb begin
    push_word.sum = SumBits'(rsum_q[0]) + SumBits'(rsum_q[1]) + SumBits'(rsum_q[2])
                  + SumBits'(rsum_q[3]) + SumBits'(rsum_q[4]);
    push_word.out_row     = s4_orow_q;
    push_word.out_col     = s4_ocol_q;
    push_word.out_channel = s4_ch_q;
    push_word.last        = s4_last_q;
  end

  out_item_t          fifo_mem [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]    cnt_q;
  logic               out_acc;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_mem[rd_ptr_q];
  assign out_acc     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (s4_res_q) begin
      fifo_mem[wr_ptr_q] <= push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      occ_q    <= '0;
    end else begin
      if (s4_res_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {{FifoAw{1'b0}}, s4_res_q} - {{FifoAw{1'b0}}, out_acc};
      occ_q <= occ_q + {3'd0, produce} - {3'd0, out_acc};
    end
  end

  // Results in flight plus queued never exceed the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(FifoDepth))
    else $error("result credit count above queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= occ_q)
    else $error("queue holds more words than were credited");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (row_q == '0) && (col_q == '0))
    else $error("plane position not restarted after register write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_res_q |-> (cnt_q != 4'(FifoDepth)))
    else $error("result pushed into a full queue");

endmodule

`default_nettype wire
